FILE: hw/rtl/fcc_pkg.sv
// Shared types and constants of the frustum culling classifier.
package fcc_pkg;

   localparam int NUM_PLANES = 6;
   localparam int PLANE_W    = 64;
   localparam int NORM_W     = 14;
   localparam int NORM_FRAC  = 13;
   localparam int OFS_W      = 22;
   localparam int BAND_W     = 23;
   localparam int ACT_W      = 2;
   localparam int COV_W      = 2;
   localparam int ADDR_W     = 6;
   localparam int IDX_W      = 3;
   localparam int DATA_W     = 64;
   // distance must hold the band scaled up by NORM_FRAC (13) fraction bits, and its negation
   localparam int DIST_MIN_W = BAND_W + NORM_FRAC + 2;

   typedef logic [ACT_W-1:0] action_type;
   localparam action_type ACT_POINT  = 2'd0;
   localparam action_type ACT_BOX    = 2'd1;
   localparam action_type ACT_SPHERE = 2'd2;

   typedef logic [COV_W-1:0] coverage_type;
   localparam coverage_type COV_NONE = 2'd0;
   localparam coverage_type COV_PART = 2'd1;
   localparam coverage_type COV_FULL = 2'd2;

   localparam logic [IDX_W-1:0] REG_TOL = 3'd6;

   // running verdict of one word as it moves down the chain
   typedef struct packed {
      logic vld;
      logic none;
      logic part;
      logic enc;
      logic encs;
      logic ovl;
      logic ovls;
   } flags_type;

endpackage

FILE: hw/rtl/fcc_cell.sv
// One plane cell: products, plane distance, then verdict merge, three stages.
module fcc_cell import fcc_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [PLANE_W-1:0]                     plane,
   input  flags_type                              up_flags,
   input  logic [6*COORD_WIDTH+BAND_W+ACT_W-1:0]  up_pay,
   output flags_type                              dn_flags,
   output logic [6*COORD_WIDTH+BAND_W+ACT_W-1:0]  dn_pay
);

   localparam int PAY_W  = 6*COORD_WIDTH + BAND_W + ACT_W;
   localparam int PROD_W = COORD_WIDTH + NORM_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int DIST_W = (SUM_W > DIST_MIN_W) ? SUM_W : DIST_MIN_W;
   localparam int BAND_LSB = 6*COORD_WIDTH;
   localparam int ACT_LSB  = BAND_LSB + BAND_W;

   flags_type                  s1_flags_ff, s2_flags_ff, s3_flags_ff, s3_flags_in;
   logic [PAY_W-1:0]           s1_pay_ff, s2_pay_ff, s3_pay_ff;
   logic signed [PROD_W-1:0]   pa_ff [3];
   logic signed [PROD_W-1:0]   pb_ff [3];
   logic signed [PROD_W-1:0]   pa_in [3];
   logic signed [PROD_W-1:0]   pb_in [3];
   logic signed [DIST_W-1:0]   a_ff, b_ff, a_in, b_in;
   logic signed [NORM_W-1:0]   nrm [3];
   logic signed [COORD_WIDTH-1:0] lo [3];
   logic signed [COORD_WIDTH-1:0] hi [3];
   logic signed [COORD_WIDTH-1:0] near_c [3];
   logic signed [COORD_WIDTH-1:0] far_c [3];
   logic signed [OFS_W-1:0]    ofs;
   action_type                 up_act, s2_act;
   logic [BAND_W-1:0]          s2_band;
   logic signed [DIST_W-1:0]   band_x, thr_s, thr_e, neg_s;

   assign up_act  = up_pay[ACT_LSB +: ACT_W];
   assign s2_act  = s2_pay_ff[ACT_LSB +: ACT_W];
   assign s2_band = s2_pay_ff[BAND_LSB +: BAND_W];
   assign ofs     = signed'(plane[OFS_W-1:0]);

   // stage 1: pick box corners by normal sign (the first point for other actions), multiply
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nrm[k] = signed'(plane[PLANE_W-1-k*NORM_W -: NORM_W]);
         lo[k]  = signed'(up_pay[k*COORD_WIDTH +: COORD_WIDTH]);
         hi[k]  = signed'(up_pay[(3+k)*COORD_WIDTH +: COORD_WIDTH]);
         if (up_act != ACT_BOX) begin
            near_c[k] = lo[k];
            far_c[k]  = lo[k];
         end else if (nrm[k][NORM_W-1]) begin
            near_c[k] = hi[k];
            far_c[k]  = lo[k];
         end else begin
            near_c[k] = lo[k];
            far_c[k]  = hi[k];
         end
         pa_in[k] = nrm[k] * near_c[k];
         pb_in[k] = nrm[k] * far_c[k];
      end
   end

   // stage 2: sum the products and the scaled offset
   always_comb begin
      a_in = DIST_W'(pa_ff[0]) + DIST_W'(pa_ff[1]) + DIST_W'(pa_ff[2])
           + (DIST_W'(ofs) <<< NORM_FRAC);
      b_in = DIST_W'(pb_ff[0]) + DIST_W'(pb_ff[1]) + DIST_W'(pb_ff[2])
           + (DIST_W'(ofs) <<< NORM_FRAC);
   end

   // stage 3: compare against the band and merge into the running verdict
   always_comb begin
      band_x = signed'(DIST_W'({s2_band, {NORM_FRAC{1'b0}}}));
      thr_s  = (s2_act == ACT_BOX) ? '0 : band_x;
      thr_e  = (s2_act == ACT_SPHERE) ? band_x : '0;
      neg_s  = -thr_s;
      s3_flags_in      = s2_flags_ff;
      s3_flags_in.none = s2_flags_ff.none | (b_ff < neg_s);
      s3_flags_in.part = s2_flags_ff.part
                       | ((a_ff <= thr_s) && ((s2_act == ACT_BOX) || (a_ff >= neg_s)));
      s3_flags_in.enc  = s2_flags_ff.enc  & (a_ff >= thr_e);
      s3_flags_in.encs = s2_flags_ff.encs & (a_ff > thr_e);
      s3_flags_in.ovl  = s2_flags_ff.ovl  & (b_ff >= neg_s);
      s3_flags_in.ovls = s2_flags_ff.ovls & (b_ff > neg_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_flags_ff <= '0;
         s2_flags_ff <= '0;
         s3_flags_ff <= '0;
      end else begin
         s1_flags_ff <= up_flags;
         s2_flags_ff <= s1_flags_ff;
         s3_flags_ff <= s3_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pay_ff <= up_pay;
      s2_pay_ff <= s1_pay_ff;
      s3_pay_ff <= s2_pay_ff;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
   end

   assign dn_flags = s3_flags_ff;
   assign dn_pay   = s3_pay_ff;

endmodule

FILE: hw/rtl/frustum_culling_classifier.sv
// Top level: plane registers, input stage, chain of plane cells, result register.
//
//   channel   ports                        handshake
//   request   req_* fields                 start high, busy low
//   result    rsp_* fields, rsp_valid      one-cycle strobe, no back-pressure
//   config    psel/penable/pwrite/paddr    APB write, pready always high
//
// A new word is taken every cycle; busy is high only during reset.
// With N = min(PLANE_COUNT, 6) cells, the pipeline is one input stage, three
// stages per plane cell (multiply, sum, compare), and one result register.
// Reset clears the pipeline flags (not its data) and sets all plane registers and the tolerance to 0.
// The result side cannot stall, so nothing in the chain ever holds.
module frustum_culling_classifier import fcc_pkg::*; #(
   parameter int PLANE_COUNT = 6,
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ACT_W-1:0]              req_action,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic [BAND_W-1:0]             req_radius,
   output logic                          rsp_valid,
   output logic [COV_W-1:0]              rsp_coverage,
   output logic                          rsp_encloses,
   output logic                          rsp_encloses_strict,
   output logic                          rsp_overlaps,
   output logic                          rsp_overlaps_strict,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ADDR_W-1:0]             paddr,
   input  logic [DATA_W-1:0]             pwdata,
   output logic [DATA_W-1:0]             prdata,
   output logic                          pready
);

   localparam int CELLS = (PLANE_COUNT > NUM_PLANES) ? NUM_PLANES : PLANE_COUNT;
   localparam int PAY_W = 6*COORD_WIDTH + BAND_W + ACT_W;
   localparam int ACT_LSB = 6*COORD_WIDTH + BAND_W;

   logic [PLANE_W-1:0] plane_ff [NUM_PLANES];
   logic [BAND_W-1:0]  tol_ff;
   logic               wr;
   logic [IDX_W-1:0]   idx;
   logic               accept;
   logic [BAND_W-1:0]  band;
   flags_type          in_flags_ff, in_flags_in;
   logic [PAY_W-1:0]   in_pay_ff;
   flags_type          chain_flags [CELLS+1];
   logic [PAY_W-1:0]   chain_pay [CELLS+1];
   flags_type          last;
   action_type         last_act;
   logic               rsp_valid_ff;
   coverage_type       cov_ff, cov_in;
   logic               enc_ff, encs_ff, ovl_ff, ovls_ff;

   // configuration port
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;
   assign idx    = paddr[ADDR_W-1 -: IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         tol_ff <= '0;
      end else if (wr) begin
         if (idx < IDX_W'(NUM_PLANES)) begin
            plane_ff[idx] <= pwdata;
         end else if (idx == REG_TOL) begin
            tol_ff <= pwdata[BAND_W-1:0];
         end
      end
   end

   always_comb begin
      if (idx < IDX_W'(NUM_PLANES)) begin
         prdata = plane_ff[idx];
      end else if (idx == REG_TOL) begin
         prdata = DATA_W'(tol_ff);
      end else begin
         prdata = '0;
      end
   end

   // input stage
   assign busy   = reset;
   assign accept = start && !busy;
   assign band   = (req_action == ACT_POINT) ? tol_ff : req_radius;

   always_comb begin
      in_flags_in      = '0;
      in_flags_in.vld  = accept;
      in_flags_in.enc  = 1'b1;
      in_flags_in.encs = 1'b1;
      in_flags_in.ovl  = 1'b1;
      in_flags_in.ovls = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flags_ff <= '0;
      end else begin
         in_flags_ff <= in_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      in_pay_ff <= {req_action, band, req_second_z, req_second_y, req_second_x,
                    req_first_z, req_first_y, req_first_x};
   end

   assign chain_flags[0] = in_flags_ff;
   assign chain_pay[0]   = in_pay_ff;

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      fcc_cell #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .plane    (plane_ff[c]),
         .up_flags (chain_flags[c]),
         .up_pay   (chain_pay[c]),
         .dn_flags (chain_flags[c+1]),
         .dn_pay   (chain_pay[c+1])
      );
   end

   // result decode; an unknown action zeroes every verdict output, but rsp_valid is still raised
   assign last     = chain_flags[CELLS];
   assign last_act = chain_pay[CELLS][ACT_LSB +: ACT_W];

   always_comb begin
      if (last.none) begin
         cov_in = COV_NONE;
      end else if (last.part) begin
         cov_in = COV_PART;
      end else begin
         cov_in = COV_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (last_act == ACT_POINT) begin
         cov_ff  <= cov_in;
         enc_ff  <= last.enc;
         encs_ff <= last.encs;
         ovl_ff  <= last.enc;
         ovls_ff <= last.encs;
      end else if (last_act == ACT_BOX || last_act == ACT_SPHERE) begin
         cov_ff  <= cov_in;
         enc_ff  <= last.enc;
         encs_ff <= last.encs;
         ovl_ff  <= last.ovl;
         ovls_ff <= last.ovls;
      end else begin
         cov_ff  <= COV_NONE;
         enc_ff  <= 1'b0;
         encs_ff <= 1'b0;
         ovl_ff  <= 1'b0;
         ovls_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coverage        = cov_ff;
   assign rsp_encloses        = enc_ff;
   assign rsp_encloses_strict = encs_ff;
   assign rsp_overlaps        = ovl_ff;
   assign rsp_overlaps_strict = ovls_ff;

endmodule

FILE: hw/rtl/fcc_checker.sv
// Port-level checks of the classifier, bound to the top level.
module fcc_checker import fcc_pkg::*; #(
   parameter int PLANE_COUNT = 6,
   parameter int COORD_WIDTH = 24
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [COV_W-1:0] rsp_coverage,
   input logic             rsp_encloses,
   input logic             rsp_encloses_strict,
   input logic             rsp_overlaps,
   input logic             rsp_overlaps_strict
);

   localparam int CELLS = (PLANE_COUNT > NUM_PLANES) ? NUM_PLANES : PLANE_COUNT;
   localparam int LAT   = 3*CELLS + 2;

   // every taken word yields a result once it has passed the whole pipeline
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("taken word produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a taken word");

   a_full_is_strict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coverage == COV_FULL) |-> rsp_encloses_strict)
      else $error("full coverage without strict enclosure");

   // strict enclosure implies enclosure, since both test the same near-corner distance
   a_strict_enc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_encloses_strict) |-> rsp_encloses)
      else $error("strict enclosure without enclosure");

   a_strict_ovl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overlaps_strict) |-> rsp_overlaps)
      else $error("strict overlap without overlap");

endmodule

bind frustum_culling_classifier fcc_checker #(
   .PLANE_COUNT(PLANE_COUNT),
   .COORD_WIDTH(COORD_WIDTH)
) u_fcc_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_coverage        (rsp_coverage),
   .rsp_encloses        (rsp_encloses),
   .rsp_encloses_strict (rsp_encloses_strict),
   .rsp_overlaps        (rsp_overlaps),
   .rsp_overlaps_strict (rsp_overlaps_strict)
);
